FILE: src/jsec_pkg.sv
// ---------------------------------------------------------------------------
// jsec_pkg - shared types and constants for the JSON string escape codec
// Payload structs, the queued job descriptor and character constants.
// ---------------------------------------------------------------------------
`default_nettype none

package jsec_pkg;

  localparam int unsigned MAX_OUT     = 6;   // most bytes one input byte expands to
  localparam int unsigned CNT_W       = 3;   // holds 1..MAX_OUT
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic MODE_ESCAPE   = 1'b0;
  localparam logic MODE_UNESCAPE = 1'b1;

  localparam logic [7:0] CH_BSL   = 8'h5C;   // backslash
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_U     = 8'h75;   // 'u'
  localparam logic [7:0] CH_ZERO  = 8'h30;   // '0'
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CC_BS    = 8'h08;
  localparam logic [7:0] CC_FF    = 8'h0C;
  localparam logic [7:0] CC_LF    = 8'h0A;
  localparam logic [7:0] CC_CR    = 8'h0D;
  localparam logic [7:0] CC_TAB   = 8'h09;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
    logic       bad_escape;
  } out_item_t;

  // One queued job: the output bytes that one input byte produces.
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] bytes;      // bytes[0] goes out first
    logic [CNT_W-1:0]        cnt;        // 1..MAX_OUT
    logic                    data_vld;   // 0 for a bare end marker
    logic                    bad;
    logic                    last;
  } job_t;

endpackage

`default_nettype wire

FILE: src/jsec_front.sv
// ---------------------------------------------------------------------------
// jsec_front - input side of the codec
// Holds the mode register and the unescape state, and turns each accepted
// byte into at most one job descriptor for the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module jsec_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_mode,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire jsec_pkg::in_item_t in_data,
  input  wire logic              q_full,
  output logic                   q_push,
  output jsec_pkg::job_t         q_job
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_BSL  = 3'd1;
  localparam logic [2:0] PH_U    = 3'd2;
  localparam logic [2:0] PH_U1   = 3'd3;
  localparam logic [2:0] PH_U2   = 3'd4;
  localparam logic [2:0] PH_U3   = 3'd5;

  logic       mode_r;
  logic [2:0] phase_r, phase_nxt, ph;
  logic [7:0] held_r   [0:2];   // characters after \u; a fourth is never needed
  logic [7:0] held_nxt [0:2];
  logic       accept;
  logic [7:0] b;
  logic [4:0] hv_hi, hv_lo;
  logic       bad_seq;
  jsec_pkg::job_t job;

  // lower-case hex digit for a nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    hex_digit = (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h57 + {4'd0, nib});
  endfunction

  // {valid, value} of an ASCII hex digit, either case
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    hex_val = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) hex_val = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      hex_val = {1'b1, c[3:0] + 4'd9};
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign b         = in_data.in_byte;
  assign ph        = (phase_r > PH_U3) ? PH_IDLE : phase_r;
  assign hv_hi     = hex_val(held_r[2]);
  assign hv_lo     = hex_val(b);
  assign bad_seq   = !(held_r[0] == jsec_pkg::CH_ZERO && held_r[1] == jsec_pkg::CH_ZERO &&
                       hv_hi[4] && hv_lo[4]);

  always_comb begin
    job          = '0;
    job.data_vld = 1'b1;
    phase_nxt    = phase_r;
    for (int i = 0; i < 3; i++) held_nxt[i] = held_r[i];

    if (mode_r == jsec_pkg::MODE_ESCAPE) begin
      phase_nxt = PH_IDLE;
      if (b < 8'h20) begin
        job.bytes[0] = jsec_pkg::CH_BSL;
        job.cnt      = 3'd2;
        case (b)
          jsec_pkg::CC_BS:  job.bytes[1] = jsec_pkg::CH_B;
          jsec_pkg::CC_FF:  job.bytes[1] = jsec_pkg::CH_F;
          jsec_pkg::CC_LF:  job.bytes[1] = jsec_pkg::CH_N;
          jsec_pkg::CC_CR:  job.bytes[1] = jsec_pkg::CH_R;
          jsec_pkg::CC_TAB: job.bytes[1] = jsec_pkg::CH_T;
          default: begin
            job.bytes[1] = jsec_pkg::CH_U;
            job.bytes[2] = jsec_pkg::CH_ZERO;
            job.bytes[3] = jsec_pkg::CH_ZERO;
            job.bytes[4] = hex_digit(b[7:4]);
            job.bytes[5] = hex_digit(b[3:0]);
            job.cnt      = 3'd6;
          end
        endcase
      end else if (b == jsec_pkg::CH_QUOTE || b == jsec_pkg::CH_BSL) begin
        job.bytes[0] = jsec_pkg::CH_BSL;
        job.bytes[1] = b;
        job.cnt      = 3'd2;
      end else begin
        job.bytes[0] = b;
        job.cnt      = 3'd1;
      end
    end else begin
      case (ph)
        PH_IDLE: begin
          if (b == jsec_pkg::CH_BSL) begin
            phase_nxt = PH_BSL;
          end else begin
            job.bytes[0] = b;
            job.cnt      = 3'd1;
          end
        end
        PH_BSL: begin
          phase_nxt = PH_IDLE;
          job.cnt   = 3'd1;
          case (b)
            jsec_pkg::CH_B: job.bytes[0] = jsec_pkg::CC_BS;
            jsec_pkg::CH_F: job.bytes[0] = jsec_pkg::CC_FF;
            jsec_pkg::CH_N: job.bytes[0] = jsec_pkg::CC_LF;
            jsec_pkg::CH_R: job.bytes[0] = jsec_pkg::CC_CR;
            jsec_pkg::CH_T: job.bytes[0] = jsec_pkg::CC_TAB;
            jsec_pkg::CH_U: begin
              if (in_data.in_last) begin
                job.bytes[0] = jsec_pkg::CH_U;
              end else begin
                job.cnt   = 3'd0;
                phase_nxt = PH_U;
              end
            end
            default: job.bytes[0] = b;
          endcase
        end
        PH_U, PH_U1, PH_U2: begin
          if (in_data.in_last) begin
            // truncated \u: pass what was held on as literal text
            job.bytes[0] = jsec_pkg::CH_U;
            if (ph == PH_U) begin
              job.bytes[1] = b;
              job.cnt      = 3'd2;
            end else if (ph == PH_U1) begin
              job.bytes[1] = held_r[0];
              job.bytes[2] = b;
              job.cnt      = 3'd3;
            end else begin
              job.bytes[1] = held_r[0];
              job.bytes[2] = held_r[1];
              job.bytes[3] = b;
              job.cnt      = 3'd4;
            end
            phase_nxt = PH_IDLE;
          end else begin
            if (ph == PH_U)       held_nxt[0] = b;
            else if (ph == PH_U1) held_nxt[1] = b;
            else                  held_nxt[2] = b;
            phase_nxt = ph + 3'd1;
          end
        end
        PH_U3: begin
          phase_nxt    = PH_IDLE;
          job.cnt      = 3'd1;
          job.bad      = bad_seq;
          job.bytes[0] = bad_seq ? 8'h00 : {hv_hi[3:0], hv_lo[3:0]};
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end

    if (in_data.in_last) begin
      phase_nxt = PH_IDLE;
      job.last  = 1'b1;
      if (job.cnt == 3'd0) begin
        job.bytes    = '0;
        job.cnt      = 3'd1;
        job.data_vld = 1'b0;
        job.bad      = 1'b0;
      end
    end
  end

  assign q_job  = job;
  assign q_push = accept && (job.cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= jsec_pkg::MODE_ESCAPE;
      phase_r <= PH_IDLE;
    end else begin
      if (cfg_valid && cfg_ready) mode_r <= cfg_mode;
      if (accept) phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 3; i++) held_r[i] <= held_nxt[i];
    end
  end

endmodule

`default_nettype wire

FILE: src/jsec_queue.sv
// ---------------------------------------------------------------------------
// jsec_queue - job queue between front and back
// Small register FIFO of job descriptors, read from the head.
// ---------------------------------------------------------------------------
`default_nettype none

module jsec_queue #(
  parameter int unsigned DEPTH = jsec_pkg::QUEUE_DEPTH   // 2 or more
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire jsec_pkg::job_t push_job,
  input  wire logic           pop,
  output jsec_pkg::job_t      head,
  output logic                full,
  output logic                empty
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  jsec_pkg::job_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop)      cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("job queue read while empty");

endmodule

`default_nettype wire

FILE: src/jsec_back.sv
// ---------------------------------------------------------------------------
// jsec_back - output side of the codec
// Walks the head job into the output register one byte per cycle unless stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module jsec_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire jsec_pkg::job_t head,
  input  wire logic           empty,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output jsec_pkg::out_item_t out_data
);

  logic [jsec_pkg::CNT_W-1:0] k_r, k_nxt;
  logic                       out_valid_r, out_valid_nxt;
  jsec_pkg::out_item_t        out_data_r, out_data_nxt;
  logic                       load, at_end;

  assign load   = !empty && (!out_valid_r || !out_stall);
  assign at_end = (k_r == head.cnt - 1'b1);
  assign pop    = load && at_end;

  always_comb begin
    out_data_nxt.out_byte   = head.bytes[k_r];
    out_data_nxt.out_valid  = head.data_vld;
    out_data_nxt.out_last   = head.last && at_end;
    out_data_nxt.bad_escape = head.bad;
    k_nxt                   = k_r;
    out_valid_nxt           = out_valid_r && out_stall;
    if (load) begin
      out_valid_nxt = 1'b1;
      k_nxt         = at_end ? '0 : k_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_index_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (k_r < head.cnt))
    else $error("byte index past end of job");

  a_index_idle: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> (k_r == '0))
    else $error("byte index not cleared with queue empty");

endmodule

`default_nettype wire

FILE: src/json_string_escape_codec.sv
// ---------------------------------------------------------------------------
// json_string_escape_codec - streaming JSON string escape / unescape
//
// Input channel (in_valid / in_stall / in_data): one string byte per
// transaction, in_last on the final byte. Output channel (out_valid /
// out_stall / out_data): one converted byte per transaction; out_last on the
// last transaction of a string, and a string ending without data yields a
// bare end marker (out_data.out_valid = 0). Config channel (cfg_valid /
// cfg_ready / cfg_mode): 0 escape, 1 unescape; always ready, write only idle.
//
// Each job is registered in the queue, then in the output register.
// Throughput: one input byte per cycle while each yields at most one output
// byte and out_stall stays low; an escape producing N bytes holds the output
// register until all N are out, as the back end emits one byte per cycle. The
// QUEUE_DEPTH-entry job queue absorbs the gap; input stalls only when it fills.
//
// Reset: mode returns to escape, escape phase to idle, queue and output
// register empty. A stalled receiver holds the output register; the queue
// then fills and in_stall rises.
// ---------------------------------------------------------------------------
`default_nettype none

module json_string_escape_codec #(
  parameter int unsigned QUEUE_DEPTH = jsec_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_mode,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire jsec_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output jsec_pkg::out_item_t     out_data
);

  // front -> queue -> back
  jsec_pkg::job_t push_job, head;
  logic           push, pop, full, empty;

  // front classifies bytes and tracks the \u state
  jsec_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_mode  (cfg_mode),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_full    (full),
    .q_push    (push),
    .q_job     (push_job)
  );

  // decoupling queue of job descriptors
  jsec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  // back end serializes each job onto the output channel
  jsec_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
